### src/mchf_pkg.sv
// Shared types, constants and CRC helpers for the multicast hash filter builder.
package mchf_pkg;

  localparam int unsigned AddrW      = 48;
  localparam int unsigned HashW      = 64;
  localparam int unsigned HashIdxW   = $clog2(HashW);
  localparam int unsigned RxModeW    = 3;
  localparam int unsigned HashLimit  = 32;
  localparam int unsigned CountW     = $clog2(HashLimit + 2);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutUserW   = 2;
  localparam int unsigned OutDataW   = 120;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;

  localparam logic [CountW-1:0] CountMax = CountW'(HashLimit + 1);

  // rx_mode_flags bit positions
  localparam int unsigned RxEnBit      = 0;
  localparam int unsigned RxPromiscBit = 1;
  localparam int unsigned RxAllMcBit   = 2;

  localparam logic [CfgIdxW-1:0] RegRxMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStation = 1'b1;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_PROMISC  = 2'd1,
    MODE_ALLMULTI = 2'd2,
    MODE_HASH     = 2'd3
  } filter_mode_e;

  // Reflected CRC-32, init all ones, no final inversion; bit 0 of the address goes first.
  // Only evaluated on constants, to build the XOR network columns.
  function automatic logic [31:0] crc32_refl(input logic [AddrW-1:0] addr);
    logic [31:0] crc;
    logic        fb;
    crc = '1;
    for (int i = 0; i < AddrW; i++) begin
      fb  = crc[0] ^ addr[i];
      crc = (crc >> 1) ^ (fb ? CrcPoly : 32'd0);
    end
    return crc;
  endfunction

endpackage

### src/multicast_hash_filter_builder.sv
// Top level of the multicast hash filter builder: input stage, filter state, result register.
//
// Usage:
//   Slave stream (s_axis_*) carries one multicast address per transfer; tuser flags
//   mark the start of a new list and whether the address is to be added.
//   Master stream (m_axis_*) returns one filter snapshot per input transfer:
//   mode in tuser, hash table, node address and changed flag in tdata.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i):
//   index 0 is the rx mode flags, index 1 the station address. Write only when idle.
// The input register loads at the transfer edge; the CRC XOR network and table update
//   then load the result register once it is empty or being read.
// Throughput: one item per cycle while the receiver takes results; the CRC network and
//   the table OR are the one combinational stage between the two registers.
// Reset clears the table, the list count, the cached node address, the
//   configuration registers and both pipeline slots.
// When the receiver stalls, the result register holds and the input register
//   fills; tready drops only once both are occupied, nothing is lost.
module multicast_hash_filter_builder import mchf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // address stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [47:0] mc_address
  input  logic [InUserW-1:0]  s_axis_tuser,   // [0] first_of_list, [1] address_valid
  // filter result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [63:0] hash_table, [111:64] node_address,
                                              // [112] node_address_changed, [119:113] zero
  output logic [OutUserW-1:0] m_axis_tuser    // [1:0] filter_mode
);

  // configuration registers
  logic [RxModeW-1:0] rx_mode_q;
  logic [AddrW-1:0]   station_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_mode_q <= '0;
      station_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRxMode:  rx_mode_q <= cfg_wdata_i[RxModeW-1:0];
        RegStation: station_q <= cfg_wdata_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic             in_first_q;
  logic             in_addr_vld_q;
  logic [AddrW-1:0] in_addr_q;
  logic             out_valid_q;
  logic             adv;
  logic             s_xfer;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_first_q    <= s_axis_tuser[0];
      in_addr_vld_q <= s_axis_tuser[1];
      in_addr_q     <= s_axis_tdata[AddrW-1:0];
    end
  end

  // hash and filter state update
  logic [HashIdxW-1:0] hash_idx;

  mchf_hash u_hash (
    .addr_i (in_addr_q),
    .idx_o  (hash_idx)
  );

  logic [HashW-1:0]  hash_q, hash_d, hash_base;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_base;
  logic [AddrW-1:0]  cached_q, node;
  filter_mode_e      mode;
  logic [HashW-1:0]  table_out;
  logic              node_changed;

  always_comb begin
    hash_base = in_first_q ? '0 : hash_q;
    cnt_base  = in_first_q ? '0 : cnt_q;
    hash_d    = hash_base;
    cnt_d     = cnt_base;
    if (in_addr_vld_q) begin
      hash_d = hash_base | (HashW'(1) << hash_idx);
      if (cnt_base < CountMax) begin
        cnt_d = cnt_base + CountW'(1);
      end
    end

    table_out = '0;
    if (!rx_mode_q[RxEnBit]) begin
      mode = MODE_DISABLED;
      node = '0;
    end else begin
      node = station_q;
      if (rx_mode_q[RxPromiscBit]) begin
        mode = MODE_PROMISC;
      end else if (rx_mode_q[RxAllMcBit] || cnt_d > CountW'(HashLimit)) begin
        mode = MODE_ALLMULTI;
      end else begin
        mode      = MODE_HASH;
        table_out = hash_d;
      end
    end
    node_changed = (node != cached_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      cnt_q    <= '0;
      cached_q <= '0;
    end else if (adv) begin
      hash_q   <= hash_d;
      cnt_q    <= cnt_d;
      cached_q <= node;
    end
  end

  // result register
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {(OutDataW - HashW - AddrW - 1)'(0), node_changed, node, table_out};
      out_user_q <= OutUserW'(mode);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input slot empty but not ready");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountMax)
    else $error("list count above saturation value");

  a_adv_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item did not reach result register");

  a_table_zero_unless_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != OutUserW'(MODE_HASH)) |-> m_axis_tdata[HashW-1:0] == '0)
    else $error("hash table nonzero outside hash mode");

endmodule

### src/mchf_hash.sv
// CRC-32 hash of a 48-bit address reduced to a 6-bit table index, as a flat XOR network.
module mchf_hash import mchf_pkg::*; (
  input  logic [AddrW-1:0]    addr_i,
  output logic [HashIdxW-1:0] idx_o
);

  // CRC is affine in the data: index = crc(0) ^ XOR of the columns of set bits
  localparam logic [31:0] CrcZero = crc32_refl('0);

  logic [HashIdxW-1:0] term [AddrW];

  for (genvar j = 0; j < AddrW; j++) begin : g_col
    localparam logic [31:0] ColCrc = crc32_refl(AddrW'(1) << j) ^ CrcZero;
    assign term[j] = addr_i[j] ? ColCrc[HashIdxW-1:0] : '0;
  end

  always_comb begin
    idx_o = CrcZero[HashIdxW-1:0];
    for (int j = 0; j < AddrW; j++) begin
      idx_o = idx_o ^ term[j];
    end
  end

endmodule
